// ===== rtl/bf3h_pkg.sv =====
// shared types and constants for the three-hash bloom filter
package bf3h_pkg;

	// running hash width
	localparam int HASH_W = 64;

	// djb hash starting value
	localparam logic [HASH_W-1:0] DJB_START = 64'd5381;

	// modulo: one byte-fold step, then compare-subtract steps
	// eight bytes times weights below the length stay under 2^QUOT_W lengths
	localparam int FOLD_BYTES = HASH_W / 8;
	localparam int QUOT_W = 11;
	localparam int SUB_PER_STEP = 4;
	localparam int SUB_STEPS = (QUOT_W + SUB_PER_STEP) / SUB_PER_STEP;
	localparam int MOD_STEPS = 1 + SUB_STEPS;
	localparam int STEP_CNT_W = $clog2(MOD_STEPS);

	// key kind codes
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// control to one modulo lane
	typedef struct packed {
		logic load;
		logic fold;
		logic step;
	} mod_ctl_t;

endpackage

// ===== rtl/bf3h_ram.sv =====
// generic single-address ram with registered read
module bf3h_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 800,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bf3h_mod.sv =====
// one lane of the 64-bit modulo by the filter length: byte fold, then subtract ladder
module bf3h_mod #(
	parameter int LEN = 800,
	parameter int IW = (LEN > 1) ? $clog2(LEN) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bf3h_pkg::mod_ctl_t          ctl,
	input  logic [bf3h_pkg::HASH_W-1:0] value,
	output logic [IW-1:0]               rem
);

	import bf3h_pkg::*;

	localparam int SW = IW + QUOT_W;
	localparam int DW = IW + SUB_STEPS * SUB_PER_STEP;
	localparam logic [DW-1:0] DIV_TOP = DW'(LEN) << (DW - IW - 1);

	// weight of hash byte i: 256^i mod LEN
	function automatic logic [IW-1:0] byte_weight(input int i);
		longint w;
		w = 1 % LEN;
		for (int k = 0; k < i; k++) begin
			w = (w * 256) % LEN;
		end
		return IW'(w);
	endfunction

	logic [HASH_W-1:0] val_q;
	logic [SW-1:0]     rem_q;
	logic [SW-1:0]     rem_nx;
	logic [DW-1:0]     div_q;
	logic [DW-1:0]     div_nx;
	logic [SW-1:0]     part [FOLD_BYTES];
	logic [SW-1:0]     fold_sum;

	// each hash byte scaled by its weight
	for (genvar g = 0; g < FOLD_BYTES; g++) begin : g_part
		localparam logic [IW-1:0] WEIGHT = byte_weight(g);
		assign part[g] = SW'(val_q[8*g +: 8]) * SW'(WEIGHT);
	end

	// folded value, congruent to the hash
	always_comb begin
		fold_sum = '0;
		for (int i = 0; i < FOLD_BYTES; i++) begin
			fold_sum = fold_sum + part[i];
		end
	end

	// compare and subtract shifted lengths, largest first
	always_comb begin
		logic [DW-1:0] r;
		logic [DW-1:0] d;
		r = DW'(rem_q);
		d = div_q;
		for (int i = 0; i < SUB_PER_STEP; i++) begin
			if (r >= d) begin
				r = r - d;
			end
			d = d >> 1;
		end
		rem_nx = SW'(r);
		div_nx = d;
	end

	// remainder and divisor ladder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			div_q <= '0;
		end else if (ctl.load) begin
			rem_q <= '0;
			div_q <= '0;
		end else if (ctl.fold) begin
			rem_q <= fold_sum;
			div_q <= DIV_TOP;
		end else if (ctl.step) begin
			rem_q <= rem_nx;
			div_q <= div_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q <= value;
		end
	end

	assign rem = rem_q[IW-1:0];

endmodule

// ===== rtl/bloom_filter_three_hash.sv =====
// bloom filter over byte-string keys with bkdr, ap and djb hashes
//
//  channel  | handshake                  | words
//  ---------+----------------------------+-------------------------------------
//  key in   | start, busy (taken: start  | kind, key_byte, byte_valid, last
//           | high while busy low)       |
//  result   | done (one-cycle strobe)    | maybe_present (queries only)
//
// Key bytes are taken one per cycle while busy is low. The word with last set
// makes busy rise for the byte fold and subtract ladder of the three moduli
// and the three accesses to the single bit-store port, and on a query for a
// final result state as well. A query result strobes on done in the cycle in
// which busy falls again.
// After reset a clearing pass writes all EXPECTED_KEYS*BITS_PER_KEY bits
// (one per cycle) with busy high. done cannot be held off by the receiver.
module bloom_filter_three_hash #(
	parameter int EXPECTED_KEYS = 100,
	parameter int BITS_PER_KEY = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       kind,
	input  logic [7:0] key_byte,
	input  logic       byte_valid,
	input  logic       last,
	output logic       done,
	output logic       maybe_present
);

	import bf3h_pkg::*;

	localparam int LEN = EXPECTED_KEYS * BITS_PER_KEY;
	localparam int IW = (LEN > 1) ? $clog2(LEN) : 1;
	localparam logic [IW-1:0] LAST_ADDR = IW'(LEN - 1);
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(MOD_STEPS - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_MOD   = 5'b00100,
		ST_ACC   = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		OP_FIRST  = 2'd0,
		OP_SECOND = 2'd1,
		OP_THIRD  = 2'd2
	} op_t;

	state_t state_q, state_nx;
	op_t    op_q;

	logic                  accept;
	logic                  vld_s1, kind_s1, bvalid_s1, last_s1;
	logic [7:0]            byte_s1;
	logic [HASH_W-1:0]     bkdr_q, ap_q, djb_q;
	logic                  odd_q;
	logic [HASH_W-1:0]     b_ext, bkdr_nx, ap_nx, djb_nx;
	logic                  key_end;
	logic                  kind_q;
	logic [IW-1:0]         clr_q;
	logic [STEP_CNT_W-1:0] step_q;
	mod_ctl_t              mod_ctl;
	logic [IW-1:0]         rem_bkdr, rem_ap, rem_djb;
	logic                  ram_we, ram_wdata, ram_rdata;
	logic [IW-1:0]         ram_addr;
	logic                  acc_q, done_q, maybe_q;

	// input handshake
	assign key_end = vld_s1 & last_s1;
	assign busy = (state_q != ST_RUN) | key_end;
	assign accept = start & ~busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			byte_s1 <= key_byte;
			bvalid_s1 <= byte_valid;
			last_s1 <= last;
		end
	end

	// hash update with the sign-extended byte
	always_comb begin
		b_ext = {{(HASH_W-8){byte_s1[7]}}, byte_s1};
		bkdr_nx = bkdr_q;
		ap_nx = ap_q;
		djb_nx = djb_q;
		if (bvalid_s1) begin
			bkdr_nx = (bkdr_q << 5) - bkdr_q + b_ext;
			if (odd_q) begin
				ap_nx = ap_q ^ ~((ap_q << 11) ^ b_ext ^ (ap_q >> 5));
			end else begin
				ap_nx = ap_q ^ (ap_q << 7) ^ b_ext ^ (ap_q >> 3);
			end
			djb_nx = djb_q + (djb_q << 5) + b_ext;
		end
	end

	// running hashes, restarted after each key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bkdr_q <= '0;
			ap_q <= '0;
			djb_q <= DJB_START;
			odd_q <= 1'b0;
		end else if (key_end) begin
			bkdr_q <= '0;
			ap_q <= '0;
			djb_q <= DJB_START;
			odd_q <= 1'b0;
		end else if (vld_s1 && bvalid_s1) begin
			bkdr_q <= bkdr_nx;
			ap_q <= ap_nx;
			djb_q <= djb_nx;
			odd_q <= ~odd_q;
		end
	end

	// key kind held for the access phase
	always_ff @(posedge clk) begin
		if (key_end) begin
			kind_q <= kind_s1;
		end
	end

	// modulo lanes: load, fold on the first step, then the subtract ladder
	assign mod_ctl.load = key_end;
	assign mod_ctl.fold = (state_q == ST_MOD) & (step_q == '0);
	assign mod_ctl.step = (state_q == ST_MOD) & (step_q != '0);

	bf3h_mod #(.LEN(LEN), .IW(IW)) u_mod_bkdr (
		.clk(clk), .arst_n(arst_n), .ctl(mod_ctl), .value(bkdr_nx), .rem(rem_bkdr)
	);

	bf3h_mod #(.LEN(LEN), .IW(IW)) u_mod_ap (
		.clk(clk), .arst_n(arst_n), .ctl(mod_ctl), .value(ap_nx), .rem(rem_ap)
	);

	bf3h_mod #(.LEN(LEN), .IW(IW)) u_mod_djb (
		.clk(clk), .arst_n(arst_n), .ctl(mod_ctl), .value(djb_nx), .rem(rem_djb)
	);

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_nx = ST_RUN;
				end
			end
			ST_RUN: begin
				if (key_end) begin
					state_nx = ST_MOD;
				end
			end
			ST_MOD: begin
				if (step_q == LAST_STEP) begin
					state_nx = ST_ACC;
				end
			end
			ST_ACC: begin
				if (op_q == OP_THIRD) begin
					state_nx = (kind_q == KIND_QUERY) ? ST_FIN : ST_RUN;
				end
			end
			ST_FIN: begin
				state_nx = ST_RUN;
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	// sequencer registers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			step_q <= '0;
			op_q <= OP_FIRST;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_MOD) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (state_q == ST_ACC) begin
				unique case (op_q)
					OP_FIRST:  op_q <= OP_SECOND;
					OP_SECOND: op_q <= OP_THIRD;
					default:   op_q <= OP_FIRST;
				endcase
			end else begin
				op_q <= OP_FIRST;
			end
		end
	end

	// bit store port: clearing sweep, then set or probe the three bits
	always_comb begin
		ram_addr = clr_q;
		if (state_q == ST_ACC) begin
			unique case (op_q)
				OP_FIRST:  ram_addr = rem_bkdr;
				OP_SECOND: ram_addr = rem_ap;
				default:   ram_addr = rem_djb;
			endcase
		end
	end

	assign ram_we = (state_q == ST_CLEAR) | ((state_q == ST_ACC) & (kind_q == KIND_INSERT));
	assign ram_wdata = (state_q == ST_ACC);

	bf3h_ram #(.WIDTH(1), .DEPTH(LEN), .AW(IW)) u_bits (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// and the three probed bits as they come back
	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			if (op_q == OP_FIRST) begin
				acc_q <= 1'b1;
			end else begin
				acc_q <= acc_q & ram_rdata;
			end
		end
		if (state_q == ST_FIN) begin
			maybe_q <= acc_q & ram_rdata;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
		end
	end

	assign done = done_q;
	assign maybe_present = maybe_q;

	// checks
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("result strobe without a finished probe");

	a_done_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(kind_q == KIND_QUERY))
		else $error("result strobe for an insert");

	a_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> (state_q == ST_RUN && !key_end))
		else $error("word taken outside the run state");

	a_mod_then_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && op_q == OP_FIRST) |-> $past(state_q == ST_MOD))
		else $error("bit access without a finished modulo");

endmodule

// ===== tb/bloom_filter_three_hash_tb.sv =====
// self-checking testbench for the three-hash bloom filter
module bloom_filter_three_hash_tb;
	import bf3h_pkg::*;

	localparam int EXPECTED_KEYS = 100;
	localparam int BITS_PER_KEY = 8;
	localparam logic [63:0] FILTER_LEN = 64'(EXPECTED_KEYS * BITS_PER_KEY);
	localparam int RANDOM_WORDS = 1950;
	localparam int POOL_KEYS = 32;
	localparam int POOL_MAX_LEN = 24;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT = 10;

	// one word of a key as sent to the block
	typedef struct packed {
		logic       kind;
		logic [7:0] key_byte;
		logic       byte_valid;
		logic       last;
	} key_word_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic       kind = KIND_INSERT;
	logic [7:0] key_byte = 8'h00;
	logic       byte_valid = 1'b0;
	logic       last = 1'b0;
	logic       done;
	logic       maybe_present;

	key_word_t  pending_words[$];
	logic       expected_presence[$];
	logic [7:0] key_buf[$];
	logic [7:0] pool_bytes[POOL_KEYS][POOL_MAX_LEN];
	int         pool_len[POOL_KEYS];

	// shadow of the filter state
	bit         filter_shadow[EXPECTED_KEYS * BITS_PER_KEY];
	logic [63:0] bkdr_h = 64'd0;
	logic [63:0] ap_h = 64'd0;
	logic [63:0] djb_h = DJB_START;
	logic       ap_odd = 1'b0;

	logic       word_taken;
	int         total_words = 0;
	int         words_driven = 0;
	int         fail_count = 0;
	int         idle_cycles;

	bloom_filter_three_hash #(
		.EXPECTED_KEYS(EXPECTED_KEYS),
		.BITS_PER_KEY(BITS_PER_KEY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key_byte(key_byte),
		.byte_valid(byte_valid),
		.last(last),
		.done(done),
		.maybe_present(maybe_present)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic push_word(input logic k, input logic [7:0] b, input logic v, input logic l);
		key_word_t w;
		w.kind = k;
		w.key_byte = b;
		w.byte_valid = v;
		w.last = l;
		pending_words = {pending_words, w};
	endtask

	// send key_buf as one key; kind only matters on the closing word
	task automatic push_key(input logic k, input bit tail_invalid, input int noise_pct);
		int n;
		bit closing;
		n = key_buf.size();
		for (int i = 0; i < n; i++) begin
			closing = (i == n - 1) && !tail_invalid;
			if ($urandom_range(99) < noise_pct)
				push_word(logic'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
			push_word(closing ? k : logic'($urandom_range(1)), key_buf[i], 1'b1, closing);
		end
		if (n == 0 || tail_invalid)
			push_word(k, 8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// running hashes, bit index reduction and the bit store
	task automatic track_filter_word(input key_word_t w);
		logic [63:0] b;
		logic [63:0] idx_bkdr;
		logic [63:0] idx_ap;
		logic [63:0] idx_djb;
		if (w.byte_valid) begin
			b = {{56{w.key_byte[7]}}, w.key_byte};
			bkdr_h = bkdr_h * 64'd31 + b;
			if (!ap_odd)
				ap_h = ap_h ^ ((ap_h << 7) ^ b ^ (ap_h >> 3));
			else
				ap_h = ap_h ^ ~((ap_h << 11) ^ b ^ (ap_h >> 5));
			ap_odd = ~ap_odd;
			djb_h = djb_h + (djb_h << 5) + b;
		end
		if (w.last) begin
			idx_bkdr = bkdr_h % FILTER_LEN;
			idx_ap = ap_h % FILTER_LEN;
			idx_djb = djb_h % FILTER_LEN;
			if (w.kind == KIND_INSERT) begin
				filter_shadow[int'(idx_bkdr)] = 1'b1;
				filter_shadow[int'(idx_ap)] = 1'b1;
				filter_shadow[int'(idx_djb)] = 1'b1;
			end else begin
				expected_presence = {expected_presence, (filter_shadow[int'(idx_bkdr)] &&
					filter_shadow[int'(idx_ap)] && filter_shadow[int'(idx_djb)])};
			end
			bkdr_h = 64'd0;
			ap_h = 64'd0;
			djb_h = DJB_START;
			ap_odd = 1'b0;
		end
	endtask

	// driver: a new word goes out once the current one is taken
	always @(negedge clk) begin
		int idle_pct;
		key_word_t w;
		if (words_driven < total_words / 3)
			idle_pct = 11;
		else if (words_driven < 2 * total_words / 3)
			idle_pct = 60;
		else
			idle_pct = 0;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || word_taken) begin
			if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
				w = pending_words.pop_front();
				kind <= w.kind;
				key_byte <= w.key_byte;
				byte_valid <= w.byte_valid;
				last <= w.last;
				start <= 1'b1;
				words_driven <= words_driven + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on accepted words, check each done strobe, watchdog
	always @(posedge clk or negedge arst_n) begin
		key_word_t w;
		logic want;
		if (!arst_n) begin
			word_taken <= 1'b0;
			idle_cycles <= 0;
		end else begin
			word_taken <= start && !busy;
			if (start && !busy) begin
				w.kind = kind;
				w.key_byte = key_byte;
				w.byte_valid = byte_valid;
				w.last = last;
				track_filter_word(w);
			end
			if (done) begin
				if (expected_presence.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("unexpected result word: maybe_present=%0b", maybe_present);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_presence.pop_front();
					if (maybe_present !== want) begin
						if (fail_count < REPORT_LIMIT)
							$display("maybe_present mismatch: expected %0b, got %0b",
								want, maybe_present);
						fail_count <= fail_count + 1;
					end
				end
			end
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("** bloom_filter_three_hash: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int r;
		int n;
		logic k;

		for (int i = 0; i < POOL_KEYS; i++) begin
			pool_len[i] = (i < 4) ? $urandom_range(13, POOL_MAX_LEN) : $urandom_range(1, 8);
			for (int j = 0; j < POOL_MAX_LEN; j++)
				pool_bytes[i][j] = 8'($urandom_range(255));
		end

		// empty key: query before and after its insert
		key_buf.delete();
		push_key(KIND_QUERY, 1'b0, 0);
		push_key(KIND_INSERT, 1'b0, 0);
		push_key(KIND_QUERY, 1'b0, 0);
		// sign extension edges
		key_buf = {8'h80};
		push_key(KIND_INSERT, 1'b0, 0);
		push_key(KIND_QUERY, 1'b0, 0);
		key_buf = {8'h7f};
		push_key(KIND_QUERY, 1'b0, 0);
		key_buf = {8'hff, 8'h00};
		push_key(KIND_INSERT, 1'b0, 0);
		// ignored word between keys and inside a key
		push_word(KIND_QUERY, 8'ha5, 1'b0, 1'b0);
		push_word(KIND_INSERT, 8'hff, 1'b1, 1'b0);
		push_word(KIND_INSERT, 8'h5a, 1'b0, 1'b0);
		push_word(KIND_QUERY, 8'h00, 1'b1, 1'b1);
		// key closed by a word with no byte
		push_key(KIND_QUERY, 1'b1, 0);
		key_buf = {8'h01, 8'h02, 8'h03};
		push_key(KIND_INSERT, 1'b0, 0);
		push_key(KIND_QUERY, 1'b0, 0);
		key_buf = {8'h01, 8'h02};
		push_key(KIND_QUERY, 1'b0, 0);
		key_buf = {8'h7f, 8'h80, 8'hfe};
		push_key(KIND_QUERY, 1'b1, 0);

		// random keys: mostly from a reused pool so queries hit inserted keys
		while (pending_words.size() < RANDOM_WORDS) begin
			r = $urandom_range(99);
			key_buf.delete();
			if (r < 6) begin
				push_word(logic'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
				continue;
			end else if (r < 70) begin
				n = $urandom_range(POOL_KEYS - 1);
				for (int j = 0; j < pool_len[n]; j++)
					key_buf = {key_buf, pool_bytes[n][j]};
			end else if (r < 85) begin
				n = $urandom_range(1, 6);
				repeat (n) key_buf = {key_buf, 8'($urandom_range(255))};
			end else if (r < 95) begin
				n = $urandom_range(12, 40);
				repeat (n) key_buf = {key_buf, 8'($urandom_range(255))};
			end
			k = ($urandom_range(99) < 25) ? KIND_INSERT : KIND_QUERY;
			push_key(k, $urandom_range(99) < 15, 5);
		end
		total_words = pending_words.size();

		// reset
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain
		while (pending_words.size() != 0 || start)
			@(posedge clk);
		while (expected_presence.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("** bloom_filter_three_hash: PASSED **");
		else
			$display("** bloom_filter_three_hash: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bf3h_pkg.sv
rtl/bf3h_ram.sv
rtl/bf3h_mod.sv
rtl/bloom_filter_three_hash.sv
tb/bloom_filter_three_hash_tb.sv
